FILE: rtl/actr_pkg.sv
package actr_pkg;

    localparam int KeyRows = 16;

    localparam logic [3:0] NR_128 = 4'd10;
    localparam logic [3:0] NR_192 = 4'd12;
    localparam logic [3:0] NR_256 = 4'd14;
    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    localparam logic [1:0] KEY_SIZE_128  = 2'd0;
    localparam logic [1:0] KEY_SIZE_192  = 2'd1;
    localparam logic [1:0] KEY_SIZE_256  = 2'd2;
    localparam logic [1:0] KEY_SIZE_RSVD = 2'd3;

    localparam logic [2:0] REG_KEY_A    = 3'd0;
    localparam logic [2:0] REG_KEY_B    = 3'd1;
    localparam logic [2:0] REG_KEY_C    = 3'd2;
    localparam logic [2:0] REG_KEY_D    = 3'd3;
    localparam logic [2:0] REG_KEY_SZ   = 3'd4;
    localparam logic [2:0] REG_IV_HIGH  = 3'd5;
    localparam logic [2:0] REG_IV_LOW   = 3'd6;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        first_block;
    } item_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_count;
    } result_t;

    typedef struct packed {
        logic [127:0] ctr;
        logic [127:0] data;
        logic [4:0]   count;
    } job_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  row;
        logic [1:0]  bank;
        logic [31:0] word;
    } rk_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [16] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,
        8'h1b,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    function automatic logic [3:0] nr_of(input logic [1:0] ks);
        logic [3:0] nr;
        unique case (ks)
            KEY_SIZE_256: nr = NR_256;
            KEY_SIZE_192: nr = NR_192;
            default:      nr = NR_128;
        endcase
        return nr;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte k of the state sits at [127-8k -: 8]
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)&3)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] m;
        logic [7:0] a0, a1, a2, a3, t;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            t  = a0 ^ a1 ^ a2 ^ a3;
            m[127-32*c -: 8] = a0 ^ t ^ xtime(a0 ^ a1);
            m[119-32*c -: 8] = a1 ^ t ^ xtime(a1 ^ a2);
            m[111-32*c -: 8] = a2 ^ t ^ xtime(a2 ^ a3);
            m[103-32*c -: 8] = a3 ^ t ^ xtime(a3 ^ a0);
        end
        return m;
    endfunction

endpackage

FILE: rtl/actr_queue.sv
module actr_queue
    import actr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic space,
    input  logic pop,
    output logic avail,
    output job_t head
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign space = cnt_reg != CW'(DEPTH);
    assign avail = cnt_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end
endmodule

FILE: rtl/actr_front.sv
module actr_front
    import actr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    input  logic [63:0] iv_high,
    input  logic [63:0] iv_low,
    input  logic        key_busy,
    input  logic        q_space,
    output logic        q_push,
    output job_t        q_job
);
    logic [127:0] ctr_reg, ctr_next;
    logic [127:0] base;
    logic [4:0]   n;

    assign item_ready = q_space && !key_busy;
    assign q_push     = item_valid && item_ready;

    always_comb
    begin
        base = item.first_block ? {iv_high, iv_low} : ctr_reg;
        // saturate oversized counts to a full block
        n = item.byte_count[4] ? BLOCK_BYTES : item.byte_count;
        ctr_next = ctr_reg;
        if (q_push)
        begin
            ctr_next = (n != 5'd0) ? base + 128'd1 : base;
        end
        q_job.ctr   = base;
        q_job.data  = {item.data_high, item.data_low};
        q_job.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
        end
        else
        begin
            ctr_reg <= ctr_next;
        end
    end
endmodule

FILE: rtl/actr_keyexp.sv
module actr_keyexp
    import actr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restart,
    input  logic [63:0] key_word_a,
    input  logic [63:0] key_word_b,
    input  logic [63:0] key_word_c,
    input  logic [63:0] key_word_d,
    input  logic [1:0]  key_size,
    output logic        busy,
    output rk_wr_t      rk_wr
);
    logic        busy_reg, busy_next;
    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  j_reg, j_next;
    logic [3:0]  rc_reg, rc_next;
    logic [31:0] win_reg [8];

    logic [3:0]  nr, nk;
    logic [5:0]  total;
    logic [31:0] key_w [8];
    logic [31:0] prev, far, t, w;
    logic        is_key;

    assign busy = busy_reg;

    always_comb
    begin
        nr    = nr_of(key_size);
        nk    = nr - 4'd6;
        total = {nr, 2'b00} + 6'd4;
        key_w[0] = key_word_a[63:32];
        key_w[1] = key_word_a[31:0];
        key_w[2] = key_word_b[63:32];
        key_w[3] = key_word_b[31:0];
        key_w[4] = key_word_c[63:32];
        key_w[5] = key_word_c[31:0];
        key_w[6] = key_word_d[63:32];
        key_w[7] = key_word_d[31:0];
        prev   = win_reg[7];
        far    = win_reg[3'(4'd8 - nk)];
        is_key = idx_reg < {2'b00, nk};
        t = prev;
        if (j_reg == 3'd0)
        begin
            t = sub_word({prev[23:0], prev[31:24]}) ^ {RCON[rc_reg], 24'h000000};
        end
        else if (nk == 4'd8 && j_reg == 3'd4)
        begin
            t = sub_word(prev);
        end
        w = is_key ? key_w[idx_reg[2:0]] : far ^ t;

        rk_wr.en   = busy_reg;
        rk_wr.row  = idx_reg[5:2];
        rk_wr.bank = idx_reg[1:0];
        rk_wr.word = w;

        busy_next = busy_reg;
        idx_next  = idx_reg;
        j_next    = j_reg;
        rc_next   = rc_reg;
        if (restart)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            j_next    = '0;
            rc_next   = '0;
        end
        else if (busy_reg)
        begin
            idx_next = idx_reg + 6'd1;
            j_next   = (j_reg == 3'(nk - 4'd1)) ? 3'd0 : j_reg + 3'd1;
            if (!is_key && j_reg == 3'd0)
            begin
                rc_next = rc_reg + 4'd1;
            end
            if (idx_reg == total - 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // run the schedule once out of reset for the all-zero key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            j_reg    <= '0;
            rc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            j_reg    <= j_next;
            rc_reg   <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !restart)
        begin
            for (int k = 0; k < 7; k++)
            begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[7] <= w;
        end
    end
endmodule

FILE: rtl/actr_back.sv
module actr_back
    import actr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] nr,
    input  rk_wr_t     rk_wr,
    input  logic       q_avail,
    input  job_t       q_head,
    output logic       q_pop,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);
    logic [31:0]  rk_mem [KeyRows][4];
    logic [127:0] rk_q;

    logic         busy_reg, busy_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] data_reg;
    logic [4:0]   cnt_reg;
    logic         oval_reg, oval_next;
    result_t      out_reg, out_next;

    logic         last, fin_ok, advance, start;
    logic [3:0]   rd_row;
    logic [127:0] fin, masked;

    assign result_valid = oval_reg;
    assign result       = out_reg;
    assign q_pop        = start;

    always_comb
    begin
        last    = busy_reg && rnd_reg == nr;
        fin_ok  = !oval_reg || result_ready;
        advance = busy_reg && (!last || fin_ok);
        start   = q_avail && (!busy_reg || (last && fin_ok));
        rd_row  = start ? 4'd0 : (advance ? rnd_reg + 4'd1 : rnd_reg);

        fin = sub_shift(st_reg) ^ rk_q;
        masked = data_reg ^ fin;
        for (int i = 0; i < 16; i++)
        begin
            if (5'(i) >= cnt_reg)
            begin
                masked[127-8*i -: 8] = 8'h00;
            end
        end

        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        st_next   = st_reg;
        if (advance)
        begin
            rnd_next = rnd_reg + 4'd1;
            if (rnd_reg == 4'd0)
            begin
                st_next = st_reg ^ rk_q;
            end
            else
            begin
                st_next = mix_cols(sub_shift(st_reg)) ^ rk_q;
            end
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            rnd_next  = 4'd0;
            st_next   = q_head.ctr;
        end

        oval_next = oval_reg;
        out_next  = out_reg;
        if (advance && last)
        begin
            oval_next          = 1'b1;
            out_next.out_high  = masked[127:64];
            out_next.out_low   = masked[63:0];
            out_next.out_count = cnt_reg;
        end
        else if (result_ready)
        begin
            oval_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        out_reg <= out_next;
        if (start)
        begin
            data_reg <= q_head.data;
            cnt_reg  <= q_head.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rk_wr.en)
        begin
            rk_mem[rk_wr.row][rk_wr.bank] <= rk_wr.word;
        end
        rk_q <= {rk_mem[rd_row][0], rk_mem[rd_row][1], rk_mem[rd_row][2], rk_mem[rd_row][3]};
    end
endmodule

FILE: rtl/aes_ctr_keystream_xor_core.sv
// AES counter-mode keystream XOR, one 16-byte block per beat.
// Blocks are enciphered one at a time by the single shared round unit (Nr = 10, 12 or 14 rounds).
// After reset and after any key or key-size write, the key schedule is rebuilt
// one word per cycle (44, 52 or 60 words in all); no item is accepted meanwhile.
// Reset (rst_n low, async) clears the counter, config registers and all beats in flight.
module aes_ctr_keystream_xor_core
    import actr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [63:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg, iv_high_reg, iv_low_reg;
    logic [1:0]  key_size_reg;
    logic        wr_en, restart, key_busy;
    logic [2:0]  reg_idx;
    rk_wr_t      rk_wr;
    logic        q_push, q_space, q_pop, q_avail;
    job_t        q_job, q_head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign restart = wr_en && (reg_idx == REG_KEY_A || reg_idx == REG_KEY_B ||
                               reg_idx == REG_KEY_C || reg_idx == REG_KEY_D ||
                               reg_idx == REG_KEY_SZ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg    <= '0;
            key_b_reg    <= '0;
            key_c_reg    <= '0;
            key_d_reg    <= '0;
            key_size_reg <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_KEY_A:   key_a_reg    <= pwdata;
                REG_KEY_B:   key_b_reg    <= pwdata;
                REG_KEY_C:   key_c_reg    <= pwdata;
                REG_KEY_D:   key_d_reg    <= pwdata;
                REG_KEY_SZ:  key_size_reg <= pwdata[1:0];
                REG_IV_HIGH: iv_high_reg  <= pwdata;
                REG_IV_LOW:  iv_low_reg   <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY_A:   prdata = key_a_reg;
            REG_KEY_B:   prdata = key_b_reg;
            REG_KEY_C:   prdata = key_c_reg;
            REG_KEY_D:   prdata = key_d_reg;
            REG_KEY_SZ:  prdata = {62'd0, key_size_reg};
            REG_IV_HIGH: prdata = iv_high_reg;
            REG_IV_LOW:  prdata = iv_low_reg;
            default:     prdata = '0;
        endcase
    end

    actr_keyexp u_keyexp (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .key_word_a (key_a_reg),
        .key_word_b (key_b_reg),
        .key_word_c (key_c_reg),
        .key_word_d (key_d_reg),
        .key_size   (key_size_reg),
        .busy       (key_busy),
        .rk_wr      (rk_wr)
    );

    actr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .iv_high    (iv_high_reg),
        .iv_low     (iv_low_reg),
        .key_busy   (key_busy),
        .q_space    (q_space),
        .q_push     (q_push),
        .q_job      (q_job)
    );

    actr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .space    (q_space),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head)
    );

    actr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .nr           (nr_of(key_size_reg)),
        .rk_wr        (rk_wr),
        .q_avail      (q_avail),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_no_accept_during_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        key_busy |-> !item_ready)
        else $error("item accepted while key schedule rebuilds");

    a_key_write_starts_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> key_busy)
        else $error("key write did not start schedule rebuild");

    a_result_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.out_count <= BLOCK_BYTES)
        else $error("result byte count above block size");
endmodule

FILE: test/aes_ctr_keystream_xor_core_chk.sv
module aes_ctr_keystream_xor_core_chk
    import actr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          blocks_due
);

    logic [63:0]  key_a, key_b, key_c, key_d, iv_hi, iv_lo;
    logic [1:0]   key_sz;
    logic [127:0] ctr;
    logic [31:0]  sched [60];
    result_t      blocks_q [$];

    function automatic int rounds_for(input logic [1:0] ks);
        int nr;
        if (ks == KEY_SIZE_256)
            nr = 14;
        else if (ks == KEY_SIZE_192)
            nr = 12;
        else
            nr = 10;
        return nr;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    task automatic rebuild_schedule();
        int nr;
        int nk;
        logic [31:0] kw [8];
        logic [31:0] t;
        nr = rounds_for(key_sz);
        nk = nr - 6;
        kw = '{key_a[63:32], key_a[31:0], key_b[63:32], key_b[31:0],
               key_c[63:32], key_c[31:0], key_d[63:32], key_d[31:0]};
        for (int i = 0; i < 60; i++)
            sched[i] = '0;
        for (int i = 0; i < nk; i++)
            sched[i] = kw[i];
        for (int i = nk; i < 4 * (nr + 1); i++)
        begin
            t = sched[i-1];
            if (i % nk == 0)
                t = sbox_word({t[23:0], t[31:24]}) ^ {RCON[i/nk-1], 24'h0};
            else if (nk > 6 && i % nk == 4)
                t = sbox_word(t);
            sched[i] = sched[i-nk] ^ t;
        end
    endtask

    function automatic logic [127:0] encrypt(input logic [127:0] blk);
        logic [127:0] s, t;
        logic [7:0] a0, a1, a2, a3, x;
        int nr;
        nr = rounds_for(key_sz);
        s = blk ^ {sched[0], sched[1], sched[2], sched[3]};
        for (int r = 1; r <= nr; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    t[127-8*(w+4*c) -: 8] = SBOX[s[127-8*(w+4*((c+w)&3)) -: 8]];
            s = t;
            if (r < nr)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[127-32*c -: 8];
                    a1 = t[119-32*c -: 8];
                    a2 = t[111-32*c -: 8];
                    a3 = t[103-32*c -: 8];
                    x  = a0 ^ a1 ^ a2 ^ a3;
                    s[127-32*c -: 8] = a0 ^ x ^ dbl(a0 ^ a1);
                    s[119-32*c -: 8] = a1 ^ x ^ dbl(a1 ^ a2);
                    s[111-32*c -: 8] = a2 ^ x ^ dbl(a2 ^ a3);
                    s[103-32*c -: 8] = a3 ^ x ^ dbl(a3 ^ a0);
                end
            end
            s = s ^ {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t      want, got;
        logic [127:0] mask, ks;
        logic [4:0]   n;
        if (!rst_n)
        begin
            key_a = '0; key_b = '0; key_c = '0; key_d = '0;
            iv_hi = '0; iv_lo = '0; key_sz = '0; ctr = '0;
            rebuild_schedule();
            blocks_q.delete();
            mismatches <= 0;
            blocks_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_KEY_A:   key_a = pwdata;
                    REG_KEY_B:   key_b = pwdata;
                    REG_KEY_C:   key_c = pwdata;
                    REG_KEY_D:   key_d = pwdata;
                    REG_KEY_SZ:  key_sz = pwdata[1:0];
                    REG_IV_HIGH: iv_hi = pwdata;
                    REG_IV_LOW:  iv_lo = pwdata;
                    default: ;
                endcase
                if (paddr[5:3] <= REG_KEY_SZ)
                    rebuild_schedule();
            end
            if (item_valid && item_ready)
            begin
                n = (item.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : item.byte_count;
                if (item.first_block)
                    ctr = {iv_hi, iv_lo};
                want = '0;
                if (n != 0)
                begin
                    ks = encrypt(ctr);
                    mask = ~128'h0 << (8 * (16 - n));
                    {want.out_high, want.out_low} = ({item.data_high, item.data_low} ^ ks) & mask;
                    ctr = ctr + 128'd1;
                end
                want.out_count = n;
                blocks_q.push_back(want);
            end
            if (result_valid && result_ready)
            begin
                got = result;
                if (blocks_q.size() == 0)
                begin
                    $error("result beat with no block outstanding: %h", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = blocks_q.pop_front();
                    if (got.out_high !== want.out_high)
                        $error("out_high expected %h actual %h", want.out_high, got.out_high);
                    if (got.out_low !== want.out_low)
                        $error("out_low expected %h actual %h", want.out_low, got.out_low);
                    if (got.out_count !== want.out_count)
                        $error("out_count expected %0d actual %0d", want.out_count, got.out_count);
                    if (got !== want)
                        mismatches <= mismatches + 1;
                end
            end
            blocks_due <= blocks_q.size();
        end
    end

endmodule

FILE: test/aes_ctr_keystream_xor_core_tb.sv
module aes_ctr_keystream_xor_core_tb;
    import actr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          mismatches;
    int          blocks_due;
    int          holds_asked;
    int          holds_done;
    int          quiet_cycles = 0;
    logic        no_idle;

    aes_ctr_keystream_xor_core i_dut (.*);

    aes_ctr_keystream_xor_core_chk i_chk (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .blocks_due(blocks_due)
    );

    initial clk = 1'b0;

    always #10 clk = ~clk;

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 4000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        result_ready = 1'b1;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                result_ready <= 1'b0;
                repeat (300) @(posedge clk);
                result_ready <= 1'b1;
                holds_done++;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_ready <= 1'b1;
            end
        end
    end

    // drop valid, then wait for every outstanding result
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (blocks_due != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send(input item_t it);
        int gap;
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    function automatic item_t blk(input logic [63:0] hi, input logic [63:0] lo,
                                  input logic [4:0] n, input logic first);
        item_t it;
        it.data_high   = hi;
        it.data_low    = lo;
        it.byte_count  = n;
        it.first_block = first;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic item_t random_block(input logic first);
        int pick;
        logic [4:0] n;
        pick = $urandom_range(0, 15);
        if (pick < 10)
            n = BLOCK_BYTES;
        else if (pick < 13)
            n = 5'($urandom_range(1, 15));
        else if (pick == 13)
            n = 0;
        else if (pick == 14)
            n = 5'($urandom_range(17, 31));
        else
            n = 5'($urandom_range(0, 31));
        return blk(rand64(), rand64(), n, first);
    endfunction

    task automatic load_key(input logic [1:0] ks);
        write_reg(REG_KEY_A, rand64());
        write_reg(REG_KEY_B, rand64());
        write_reg(REG_KEY_C, rand64());
        write_reg(REG_KEY_D, rand64());
        write_reg(REG_KEY_SZ, {62'h0, ks});
    endtask

    initial
    begin
        logic [1:0] ks;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        holds_asked  = 0;
        no_idle      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero key out of reset, zero IV
        send(blk('0, '0, BLOCK_BYTES, 1'b1));
        send(blk('1, '1, BLOCK_BYTES, 1'b0));
        drain();

        load_key(KEY_SIZE_128);
        write_reg(REG_IV_HIGH, rand64());
        write_reg(REG_IV_LOW, '1);
        write_reg(REG_UNMAPPED, '1);
        send(blk('1, '1, BLOCK_BYTES, 1'b1));
        send(blk('0, '0, 5'd1, 1'b0));
        send(blk('1, '1, 5'd15, 1'b0));
        send(blk(rand64(), rand64(), 5'd0, 1'b0));
        send(blk(rand64(), rand64(), 5'd0, 1'b1));
        send(blk(rand64(), rand64(), 5'd17, 1'b0));
        send(blk('1, '1, 5'd31, 1'b0));
        send(blk(rand64(), rand64(), 5'd8, 1'b0));
        drain();

        // key change mid-message: counter carries on
        load_key(KEY_SIZE_192);
        send(blk(rand64(), rand64(), BLOCK_BYTES, 1'b0));
        send(blk(rand64(), rand64(), 5'd9, 1'b0));
        drain();

        // counter wraps from all ones
        load_key(KEY_SIZE_256);
        write_reg(REG_IV_HIGH, '1);
        write_reg(REG_IV_LOW, '1);
        send(blk('1, '0, BLOCK_BYTES, 1'b1));
        send(blk('0, '1, BLOCK_BYTES, 1'b0));
        send(blk(rand64(), rand64(), 5'd16, 1'b0));
        drain();

        load_key(KEY_SIZE_RSVD);
        send(blk(rand64(), rand64(), BLOCK_BYTES, 1'b1));
        send(blk(rand64(), rand64(), 5'd4, 1'b0));
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            ks = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
            if (phase != 5)
                load_key(ks);
            write_reg(REG_IV_HIGH, ($urandom_range(0, 2) == 0) ? '1 : rand64());
            write_reg(REG_IV_LOW, ($urandom_range(0, 1) == 0) ? 64'hffff_ffff_ffff_fffc
                                                               : rand64());
            if (phase == 7)
                no_idle = 1'b1;
            for (int k = 0; k < 100; k++)
            begin
                if (phase == 2 && k == 20)
                    holds_asked++;
                if (phase == 3 && k == 50)
                    drain();
                send(random_block(k == 0 || $urandom_range(0, 11) == 0));
            end
            drain();
        end

        if (mismatches == 0 && blocks_due == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
